// ===== rtl/core/vertex_bbox_normalizer_core_assert.svh =====
// Assertion macros for the checker file of this block.
// Each expects clk and rst_n to be visible where it is used.
`ifndef VERTEX_BBOX_NORMALIZER_CORE_ASSERT_SVH
`define VERTEX_BBOX_NORMALIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define VBN_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vbn: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define VBN_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vbn: next-cycle check failed");

`endif

// ===== rtl/core/vbn_pkg.sv =====
`default_nettype none

package vbn_pkg;

    // Fixed field widths
    localparam int COORD_W       = 32;
    localparam int IDX_W         = 12;
    localparam int NORM_W        = 32;
    localparam int CNT_OUT_W     = 13;
    localparam int OUT_FRAC_BITS = 30;

    // Internal arithmetic widths
    localparam int EXT_W  = COORD_W + 1;        // hi-lo and hi+lo
    localparam int NUM_W  = COORD_W + 2;        // 2v - (hi+lo)
    localparam int MAG_W  = NUM_W;              // |num| and divider remainder
    localparam int Q_W    = OUT_FRAC_BITS + 1;  // integer bit plus fraction
    localparam int STEP_W = $clog2(Q_W);
    localparam int STEP_LAST = Q_W - 1;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t                   command;
        logic                   start_new;
        logic signed [31:0]     pos_x;
        logic signed [31:0]     pos_y;
        logic signed [31:0]     pos_z;
        logic [IDX_W-1:0]       read_index;
    } cmd_word_t;

    typedef struct packed
    {
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic                     index_valid;
        logic                     degenerate;
        logic                     overflowed;
        logic [CNT_OUT_W-1:0]     vertex_count;
    } res_word_t;

    typedef struct packed
    {
        coord_t x;
        coord_t y;
        coord_t z;
    } vertex_t;

endpackage

`default_nettype wire

// ===== rtl/core/vertex_bbox_normalizer_core.sv =====
// Vertex bounding-box normaliser. A load word (command LOAD) stores one vertex
// of signed Q16.16 coordinates in the vertex memory and widens the running
// per-axis minimum and maximum; start_new on a load empties the set first, and
// a load into a full set is dropped and raises the overflowed flag until the
// next start. A read word (command READ) returns the stored vertex at
// read_index as (2v - (max+min)) * 2^30 / E per axis, truncated toward zero, in
// Q2.30, where E is the largest of the three extents; an index at or beyond the
// vertex count gives zeros with index_valid low, and a zero E gives zeros with
// degenerate high. Loads are accepted back to back while no read is in progress.
// A read runs from acceptance to the result word in order: the memory read
// issues at acceptance, then the set-up states FETCH (numerators and the
// largest extent) and PREP (magnitudes and signs), then 31 steps of the
// restoring divider (one quotient bit per step, the three axes on three
// divider lanes at once), then the DONE state into the output register;
// the next word is accepted once the result is registered. An invalid index
// or a zero extent skips the divider, from PREP to DONE. A read whose result
// finds the output register still stalled holds until it is free. The result
// waits in the output register, so loads go on while it is held. Memory contents
// are undefined until written; there is no clearing pass after reset.
`default_nettype none

module vertex_bbox_normalizer_core
    import vbn_pkg::*;
#(
    parameter int MAX_VERTICES = 4096
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd_word,
    output logic      res_valid,
    input  logic      res_stall,
    output res_word_t res_word
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // One-hot sequencer for the read path
    typedef enum logic [4:0]
    {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_PREP  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef logic signed [EXT_W-1:0] ext_t;
    typedef logic signed [NUM_W-1:0] num_t;

    // Control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              drop_reg, drop_next;
    coord_t            lo_reg [3];
    coord_t            lo_next [3];
    coord_t            hi_reg [3];
    coord_t            hi_next [3];
    logic              res_valid_reg, res_valid_next;

    // Read path payload
    logic              valid_reg, valid_next;
    logic              degen_reg, degen_next;
    ext_t              sum_reg [3];
    ext_t              sum_next [3];
    ext_t              ext_reg [3];
    ext_t              ext_next [3];
    ext_t              e_reg, e_next;
    num_t              num_reg [3];
    num_t              num_next [3];
    logic              neg_reg [3];
    logic              neg_next [3];
    logic [MAG_W-1:0]  rem_reg [3];
    logic [MAG_W-1:0]  rem_next [3];
    logic [Q_W-1:0]    quo_reg [3];
    logic [Q_W-1:0]    quo_next [3];
    logic [STEP_W-1:0] step_reg, step_next;
    res_word_t         res_word_reg, res_word_next;

    // Vertex memory: one word holds all three axes
    vertex_t           mem [MAX_VERTICES];
    vertex_t           rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    vertex_t           mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Handshake decode
    logic              accept;
    logic              load_acc;
    logic              read_acc;

    // Load helpers
    coord_t            pos [3];
    coord_t            v_axis [3];
    logic [CNT_W-1:0]  base_count;
    logic              base_drop;
    coord_t            base_lo [3];
    coord_t            base_hi [3];
    logic              room;

    // Divider lane helpers
    logic [MAG_W:0]    trial [3];
    logic [MAG_W:0]    divisor;
    logic [NORM_W-1:0] mag_out [3];
    logic [NORM_W-1:0] norm_out [3];

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign load_acc  = accept && (cmd_word.command == CMD_LOAD);
    assign read_acc  = accept && (cmd_word.command == CMD_READ);

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    assign pos[0] = cmd_word.pos_x;
    assign pos[1] = cmd_word.pos_y;
    assign pos[2] = cmd_word.pos_z;

    assign v_axis[0] = rd_data_reg.x;
    assign v_axis[1] = rd_data_reg.y;
    assign v_axis[2] = rd_data_reg.z;

    // A start clears the set before this vertex goes in
    assign base_count = cmd_word.start_new ? '0 : count_reg;
    assign base_drop  = cmd_word.start_new ? 1'b0 : drop_reg;
    assign room       = (base_count < CNT_W'(MAX_VERTICES));

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            base_lo[a] = cmd_word.start_new ? COORD_MAX : lo_reg[a];
            base_hi[a] = cmd_word.start_new ? COORD_MIN : hi_reg[a];
        end
    end

    assign mem_we    = load_acc && room;
    assign mem_waddr = base_count[ADDR_W-1:0];
    assign mem_wdata = '{x: pos[0], y: pos[1], z: pos[2]};
    // Issue the read at acceptance; any earlier load has already been written
    assign mem_re    = read_acc;
    assign mem_raddr = ADDR_W'(cmd_word.read_index);

    // The extent is positive whenever the divider runs
    assign divisor = (MAG_W + 1)'($unsigned(e_reg));

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            // First step takes the integer bit, later steps shift the remainder up
            if (step_reg == '0)
            begin
                trial[a] = {1'b0, rem_reg[a]};
            end
            else
            begin
                trial[a] = {rem_reg[a], 1'b0};
            end
            mag_out[a]  = NORM_W'(quo_reg[a]);
            norm_out[a] = neg_reg[a] ? (~mag_out[a] + NORM_W'(1)) : mag_out[a];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_word_next  = res_word_reg;
        valid_next     = valid_reg;
        degen_next     = degen_reg;
        e_next         = e_reg;
        step_next      = step_reg;
        for (int a = 0; a < 3; a++)
        begin
            lo_next[a]  = lo_reg[a];
            hi_next[a]  = hi_reg[a];
            sum_next[a] = sum_reg[a];
            ext_next[a] = ext_reg[a];
            num_next[a] = num_reg[a];
            neg_next[a] = neg_reg[a];
            rem_next[a] = rem_reg[a];
            quo_next[a] = quo_reg[a];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (load_acc)
                begin
                    if (room)
                    begin
                        count_next = base_count + CNT_W'(1);
                        drop_next  = base_drop;
                        for (int a = 0; a < 3; a++)
                        begin
                            lo_next[a] = (pos[a] < base_lo[a]) ? pos[a] : base_lo[a];
                            hi_next[a] = (pos[a] > base_hi[a]) ? pos[a] : base_hi[a];
                        end
                    end
                    else
                    begin
                        // Full: drop the vertex, keep the bounds
                        drop_next = 1'b1;
                    end
                end
                else if (read_acc)
                begin
                    valid_next = (CMP_W'(cmd_word.read_index) < CMP_W'(count_reg));
                    for (int a = 0; a < 3; a++)
                    begin
                        sum_next[a] = EXT_W'(hi_reg[a]) + EXT_W'(lo_reg[a]);
                        ext_next[a] = EXT_W'(hi_reg[a]) - EXT_W'(lo_reg[a]);
                    end
                    state_next = ST_FETCH;
                end
            end

            ST_FETCH:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    num_next[a] = (NUM_W'(v_axis[a]) <<< 1) - NUM_W'(sum_reg[a]);
                end
                e_next = ext_reg[0];
                if (ext_reg[1] > e_next)
                begin
                    e_next = ext_reg[1];
                end
                if (ext_reg[2] > e_next)
                begin
                    e_next = ext_reg[2];
                end
                state_next = ST_PREP;
            end

            ST_PREP:
            begin
                degen_next = (count_reg != '0) && (e_reg == '0);
                step_next  = '0;
                for (int a = 0; a < 3; a++)
                begin
                    neg_next[a] = num_reg[a][NUM_W-1];
                    rem_next[a] = num_reg[a][NUM_W-1] ? MAG_W'(-num_reg[a])
                                                      : MAG_W'(num_reg[a]);
                    quo_next[a] = '0;
                end
                // Invalid index or zero extent: skip the division, report zeros
                if (!valid_reg || degen_next)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if (trial[a] >= divisor)
                    begin
                        rem_next[a] = MAG_W'(trial[a] - divisor);
                        quo_next[a] = {quo_reg[a][Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[a] = MAG_W'(trial[a]);
                        quo_next[a] = {quo_reg[a][Q_W-2:0], 1'b0};
                    end
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEP_LAST))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold until the output register is free or being emptied
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next             = 1'b1;
                    res_word_next.norm_x       = norm_out[0];
                    res_word_next.norm_y       = norm_out[1];
                    res_word_next.norm_z       = norm_out[2];
                    res_word_next.index_valid  = valid_reg;
                    res_word_next.degenerate   = degen_reg;
                    res_word_next.overflowed   = drop_reg;
                    res_word_next.vertex_count = CNT_OUT_W'(count_reg);
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= COORD_MAX;
                hi_reg[a] <= COORD_MIN;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            res_valid_reg <= res_valid_next;
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= lo_next[a];
                hi_reg[a] <= hi_next[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        valid_reg    <= valid_next;
        degen_reg    <= degen_next;
        e_reg        <= e_next;
        step_reg     <= step_next;
        res_word_reg <= res_word_next;
        for (int a = 0; a < 3; a++)
        begin
            sum_reg[a] <= sum_next[a];
            ext_reg[a] <= ext_next[a];
            num_reg[a] <= num_next[a];
            neg_reg[a] <= neg_next[a];
            rem_reg[a] <= rem_next[a];
            quo_reg[a] <= quo_next[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/vbn_checker.sv =====
`default_nettype none

`include "vertex_bbox_normalizer_core_assert.svh"

module vbn_checker
    import vbn_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_stall,
    input cmd_word_t cmd_word,
    input logic      res_valid,
    input logic      res_stall,
    input res_word_t res_word
);

    logic load_acc;
    logic read_acc;

    assign load_acc = cmd_valid && !cmd_stall && (cmd_word.command == CMD_LOAD);
    assign read_acc = cmd_valid && !cmd_stall && (cmd_word.command == CMD_READ);

    // Hold a stalled result word
    `VBN_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_word))

    // A read keeps the block busy after acceptance
    `VBN_ASSERT_NEXT(a_read_busy, read_acc, cmd_stall)

    // A load never brings out a result word
    `VBN_ASSERT_NEXT(a_load_silent, load_acc && !res_valid, !res_valid)

    // A read result does not rise in the cycle after acceptance
    `VBN_ASSERT_NEXT(a_read_latency, read_acc, !$rose(res_valid))

endmodule

bind vertex_bbox_normalizer_core vbn_checker u_vbn_checker (.*);

`default_nettype wire
